FILE: src/pepc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pepc_pkg
// Shared widths, micro-op and condition codes, program step addresses and
// the control/status structs of the polygon edge plane clipper.
// ----------------------------------------------------------------------------
package pepc_pkg;

    // vertex format
    localparam int NUM_COMP   = 5;
    localparam int COMP_IDX_W = $clog2(NUM_COMP);
    localparam int DATA_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int T_W        = FRAC_W + 1;
    localparam int DIV_CNT_W  = $clog2(FRAC_W);
    localparam int PROD_W     = (DATA_W + 1) + (T_W + 1);
    localparam int OP_W       = 3;

    // edge cases named by the opcode
    localparam logic [OP_W-1:0] OP_PASS  = OP_W'(0);
    localparam logic [OP_W-1:0] OP_ENTER = OP_W'(1);
    localparam logic [OP_W-1:0] OP_LEAVE = OP_W'(2);

    // micro-ops
    localparam int UOP_W = 4;
    localparam logic [UOP_W-1:0] UOP_NOP        = UOP_W'(0);
    localparam logic [UOP_W-1:0] UOP_T_INIT     = UOP_W'(1);
    localparam logic [UOP_W-1:0] UOP_T_STEP     = UOP_W'(2);
    localparam logic [UOP_W-1:0] UOP_T_DONE     = UOP_W'(3);
    localparam logic [UOP_W-1:0] UOP_MUL        = UOP_W'(4);
    localparam logic [UOP_W-1:0] UOP_ADD        = UOP_W'(5);
    localparam logic [UOP_W-1:0] UOP_EMIT_ISECT = UOP_W'(6);
    localparam logic [UOP_W-1:0] UOP_EMIT_CUR   = UOP_W'(7);
    localparam logic [UOP_W-1:0] UOP_LOAD_PREV  = UOP_W'(8);

    // jump conditions
    localparam int COND_W = 3;
    localparam logic [COND_W-1:0] COND_NEVER     = COND_W'(0);
    localparam logic [COND_W-1:0] COND_OP_PASS   = COND_W'(1);
    localparam logic [COND_W-1:0] COND_OP_NOCLIP = COND_W'(2);
    localparam logic [COND_W-1:0] COND_OP_LEAVE  = COND_W'(3);
    localparam logic [COND_W-1:0] COND_DIV_MORE  = COND_W'(4);
    localparam logic [COND_W-1:0] COND_COMP_MORE = COND_W'(5);

    // program step addresses
    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] STEP_PASS_CHK   = PC_W'(0);
    localparam logic [PC_W-1:0] STEP_CLIP_CHK   = PC_W'(1);
    localparam logic [PC_W-1:0] STEP_T_INIT     = PC_W'(2);
    localparam logic [PC_W-1:0] STEP_DIV        = PC_W'(3);
    localparam logic [PC_W-1:0] STEP_T_DONE     = PC_W'(4);
    localparam logic [PC_W-1:0] STEP_MUL        = PC_W'(5);
    localparam logic [PC_W-1:0] STEP_ADD        = PC_W'(6);
    localparam logic [PC_W-1:0] STEP_EMIT_ISECT = PC_W'(7);
    localparam logic [PC_W-1:0] STEP_EMIT_CUR   = PC_W'(8);
    localparam logic [PC_W-1:0] STEP_LOAD       = PC_W'(9);

    typedef struct packed {
        logic [UOP_W-1:0]  uop;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic              done;
    } ucode_word_t;

    typedef struct packed {
        logic             exec;
        logic [UOP_W-1:0] uop;
    } dp_ctrl_t;

    typedef struct packed {
        logic op_pass;
        logic op_no_clip;
        logic op_leave;
        logic div_more;
        logic comp_more;
        logic out_free;
    } dp_status_t;

endpackage

FILE: src/polygon_edge_plane_clip_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_edge_plane_clip_core
// One clipping-plane stage of a polygon clipper in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one vertex item: opcode, plane
//   distance and the five components. Output channel (out_valid/out_ready)
//   carries emitted vertices; last_of_run marks the final one of an item.
//   Opcode 0 emits the current vertex, 1 the intersection then the current
//   vertex, 2 the intersection, 3 and above nothing; every item then
//   becomes the previous vertex.
//   Timing: a microcoded sequencer runs one item at a time. Clipped edges
//   run the 16 steps of the restoring divider for t, then two steps
//   (multiply, then add) per component on the shared multiplier.
//   A stalled receiver holds the output register; the sequencer waits at
//   its emit step, and the next item is taken once the program has ended,
//   even while the last result is still waiting to be taken.
//   Reset clears the previous vertex and distance to zero.
// ----------------------------------------------------------------------------
module polygon_edge_plane_clip_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic signed [31:0]  plane_distance,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  tex_u,
    input  logic signed [31:0]  tex_v,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic signed [31:0]  out_u,
    output logic signed [31:0]  out_v,
    output logic                last_of_run
);

    logic                                                busy;
    logic                                                accept;
    pepc_pkg::dp_ctrl_t                                  ctrl;
    pepc_pkg::dp_status_t                                status;
    logic [pepc_pkg::NUM_COMP-1:0][pepc_pkg::DATA_W-1:0] vtx_in;
    logic [pepc_pkg::NUM_COMP-1:0][pepc_pkg::DATA_W-1:0] vtx_out;

    // input handshake
    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;

    // component packing
    assign vtx_in = {tex_v, tex_u, pos_z, pos_y, pos_x};

    pepc_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .status (status),
        .busy   (busy),
        .ctrl   (ctrl)
    );

    pepc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .opcode    (opcode),
        .dist_in   (plane_distance),
        .vtx_in    (vtx_in),
        .ctrl      (ctrl),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .vtx_out   (vtx_out),
        .last_out  (last_of_run)
    );

    // component unpacking
    assign out_x = vtx_out[0];
    assign out_y = vtx_out[1];
    assign out_z = vtx_out[2];
    assign out_u = vtx_out[3];
    assign out_v = vtx_out[4];

    // an accepted item always starts the program
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted item did not start the sequencer");

    // results are only produced by a running program
    a_emit_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(busy))
        else $error("output became valid with the sequencer idle");

    // an emit step never overwrites an unconsumed result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.exec && ((ctrl.uop == pepc_pkg::UOP_EMIT_ISECT) ||
                      (ctrl.uop == pepc_pkg::UOP_EMIT_CUR)) |-> status.out_free)
        else $error("emit step executed while output register was held");

endmodule

FILE: src/pepc_ucode_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pepc_ucode_rom
// Control store: one control word per program step of the clipper.
// ----------------------------------------------------------------------------
module pepc_ucode_rom (
    input  logic [pepc_pkg::PC_W-1:0] pc,
    output pepc_pkg::ucode_word_t     word
);

    // program listing
    always_comb
    begin
        word.uop    = pepc_pkg::UOP_NOP;
        word.cond   = pepc_pkg::COND_NEVER;
        word.target = pepc_pkg::STEP_PASS_CHK;
        word.done   = 1'b0;
        unique case (pc)
            pepc_pkg::STEP_PASS_CHK:
            begin
                word.cond   = pepc_pkg::COND_OP_PASS;
                word.target = pepc_pkg::STEP_EMIT_CUR;
            end
            pepc_pkg::STEP_CLIP_CHK:
            begin
                word.cond   = pepc_pkg::COND_OP_NOCLIP;
                word.target = pepc_pkg::STEP_LOAD;
            end
            pepc_pkg::STEP_T_INIT:
            begin
                word.uop = pepc_pkg::UOP_T_INIT;
            end
            pepc_pkg::STEP_DIV:
            begin
                word.uop    = pepc_pkg::UOP_T_STEP;
                word.cond   = pepc_pkg::COND_DIV_MORE;
                word.target = pepc_pkg::STEP_DIV;
            end
            pepc_pkg::STEP_T_DONE:
            begin
                word.uop = pepc_pkg::UOP_T_DONE;
            end
            pepc_pkg::STEP_MUL:
            begin
                word.uop = pepc_pkg::UOP_MUL;
            end
            pepc_pkg::STEP_ADD:
            begin
                word.uop    = pepc_pkg::UOP_ADD;
                word.cond   = pepc_pkg::COND_COMP_MORE;
                word.target = pepc_pkg::STEP_MUL;
            end
            pepc_pkg::STEP_EMIT_ISECT:
            begin
                word.uop    = pepc_pkg::UOP_EMIT_ISECT;
                word.cond   = pepc_pkg::COND_OP_LEAVE;
                word.target = pepc_pkg::STEP_LOAD;
            end
            pepc_pkg::STEP_EMIT_CUR:
            begin
                word.uop = pepc_pkg::UOP_EMIT_CUR;
            end
            pepc_pkg::STEP_LOAD:
            begin
                word.uop  = pepc_pkg::UOP_LOAD_PREV;
                word.done = 1'b1;
            end
            default:
            begin
                word.done = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/pepc_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pepc_sequencer
// Step counter with conditional jumps over the control store; holds on an
// emit step while the output register is still occupied.
// ----------------------------------------------------------------------------
module pepc_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pepc_pkg::dp_status_t   status,
    output logic                   busy,
    output pepc_pkg::dp_ctrl_t     ctrl
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [pepc_pkg::PC_W-1:0] pc_reg;
    logic [pepc_pkg::PC_W-1:0] pc_next;
    pepc_pkg::ucode_word_t     word;
    logic                      take_jump;
    logic                      stall;

    pepc_ucode_rom u_rom (
        .pc   (pc_reg),
        .word (word)
    );

    // jump condition decode
    always_comb
    begin
        unique case (word.cond)
            pepc_pkg::COND_NEVER:     take_jump = 1'b0;
            pepc_pkg::COND_OP_PASS:   take_jump = status.op_pass;
            pepc_pkg::COND_OP_NOCLIP: take_jump = status.op_no_clip;
            pepc_pkg::COND_OP_LEAVE:  take_jump = status.op_leave;
            pepc_pkg::COND_DIV_MORE:  take_jump = status.div_more;
            pepc_pkg::COND_COMP_MORE: take_jump = status.comp_more;
            default:                  take_jump = 1'b0;
        endcase
    end

    // emit steps wait for a free output register
    assign stall = ((word.uop == pepc_pkg::UOP_EMIT_ISECT) ||
                    (word.uop == pepc_pkg::UOP_EMIT_CUR)) && !status.out_free;

    // step counter
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = pepc_pkg::STEP_PASS_CHK;
        end
        else if (busy_reg && !stall)
        begin
            if (word.done)
            begin
                busy_next = 1'b0;
            end
            else if (take_jump)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= pepc_pkg::STEP_PASS_CHK;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy      = busy_reg;
    assign ctrl.exec = busy_reg && !stall;
    assign ctrl.uop  = word.uop;

endmodule

FILE: src/pepc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pepc_datapath
// Vertex registers, restoring divider for t, one multiplier and adder for
// the interpolation, and the output register.
// ----------------------------------------------------------------------------
module pepc_datapath (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  logic                                                load,
    input  logic [pepc_pkg::OP_W-1:0]                           opcode,
    input  logic [pepc_pkg::DATA_W-1:0]                         dist_in,
    input  logic [pepc_pkg::NUM_COMP-1:0][pepc_pkg::DATA_W-1:0] vtx_in,
    input  pepc_pkg::dp_ctrl_t                                  ctrl,
    output pepc_pkg::dp_status_t                                status,
    output logic                                                out_valid,
    input  logic                                                out_ready,
    output logic [pepc_pkg::NUM_COMP-1:0][pepc_pkg::DATA_W-1:0] vtx_out,
    output logic                                                last_out
);

    localparam int DW  = pepc_pkg::DATA_W;
    localparam int NC  = pepc_pkg::NUM_COMP;
    localparam int REM_W = DW + 2;

    // current item and previous vertex
    logic [pepc_pkg::OP_W-1:0]  op_reg;
    logic [DW-1:0]              dcur_reg;
    logic [NC-1:0][DW-1:0]      cur_reg;
    logic [DW-1:0]              dprev_reg;
    logic [NC-1:0][DW-1:0]      prev_reg;

    // divider and interpolation
    logic [REM_W-1:0]                rem_reg;
    logic [REM_W-1:0]                rem_next;
    logic [DW:0]                     den_reg;
    logic [pepc_pkg::FRAC_W-1:0]     quo_reg;
    logic [pepc_pkg::FRAC_W-1:0]     quo_next;
    logic                            t_zero_reg;
    logic                            t_one_reg;
    logic [pepc_pkg::T_W-1:0]        t_reg;
    logic [pepc_pkg::DIV_CNT_W-1:0]  div_cnt_reg;
    logic [pepc_pkg::COMP_IDX_W-1:0] comp_idx_reg;
    logic signed [pepc_pkg::PROD_W-1:0] prod_reg;
    logic signed [pepc_pkg::PROD_W-1:0] prod_next;
    logic [NC-1:0][DW-1:0]           isect_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [NC-1:0][DW-1:0] out_vtx_reg;
    logic                  out_last_reg;

    logic [DW:0]           den_full;
    logic [DW-1:0]         num_abs;
    logic [DW:0]           den_abs;
    logic                  t_zero_init;
    logic                  t_one_init;
    logic [REM_W-1:0]      rem_shift;
    logic signed [DW:0]    diff_s;
    logic signed [pepc_pkg::T_W:0] t_s;
    logic [DW-1:0]         isect_val;
    logic                  do_emit;

    // t setup: magnitudes and the special cases
    always_comb
    begin
        den_full    = {dprev_reg[DW-1], dprev_reg} - {dcur_reg[DW-1], dcur_reg};
        num_abs     = dprev_reg[DW-1] ? (~dprev_reg + 1'b1) : dprev_reg;
        den_abs     = den_full[DW] ? (~den_full + 1'b1) : den_full;
        t_zero_init = (den_full == '0) || (dprev_reg == '0) ||
                      (dprev_reg[DW-1] != den_full[DW]);
        t_one_init  = ({1'b0, num_abs} >= den_abs);
    end

    // one restoring division step per cycle
    always_comb
    begin
        rem_shift = {rem_reg[REM_W-2:0], 1'b0};
        if (rem_shift >= {1'b0, den_reg})
        begin
            rem_next = rem_shift - {1'b0, den_reg};
            quo_next = {quo_reg[pepc_pkg::FRAC_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_shift;
            quo_next = {quo_reg[pepc_pkg::FRAC_W-2:0], 1'b0};
        end
    end

    // interpolation of the selected component
    always_comb
    begin
        diff_s    = $signed({cur_reg[comp_idx_reg][DW-1], cur_reg[comp_idx_reg]}) -
                    $signed({prev_reg[comp_idx_reg][DW-1], prev_reg[comp_idx_reg]});
        t_s       = $signed({1'b0, t_reg});
        prod_next = diff_s * t_s;
        isect_val = prev_reg[comp_idx_reg] + prod_reg[pepc_pkg::FRAC_W +: DW];
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg   <= opcode;
            dcur_reg <= dist_in;
            cur_reg  <= vtx_in;
        end
    end

    // previous vertex, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dprev_reg <= '0;
            prev_reg  <= '0;
        end
        else if (ctrl.exec && (ctrl.uop == pepc_pkg::UOP_LOAD_PREV))
        begin
            dprev_reg <= dcur_reg;
            prev_reg  <= cur_reg;
        end
    end

    // step counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg  <= '0;
            comp_idx_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            case (ctrl.uop)
                pepc_pkg::UOP_T_INIT: div_cnt_reg  <= '0;
                pepc_pkg::UOP_T_STEP: div_cnt_reg  <= div_cnt_reg + 1'b1;
                pepc_pkg::UOP_T_DONE: comp_idx_reg <= '0;
                pepc_pkg::UOP_ADD:    comp_idx_reg <= comp_idx_reg + 1'b1;
                default:              ;
            endcase
        end
    end

    // arithmetic registers
    always_ff @(posedge clk)
    begin
        if (ctrl.exec)
        begin
            case (ctrl.uop)
                pepc_pkg::UOP_T_INIT:
                begin
                    rem_reg    <= {2'b00, num_abs};
                    den_reg    <= den_abs;
                    quo_reg    <= '0;
                    t_zero_reg <= t_zero_init;
                    t_one_reg  <= t_one_init;
                end
                pepc_pkg::UOP_T_STEP:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_next;
                end
                pepc_pkg::UOP_T_DONE:
                begin
                    if (t_zero_reg)
                    begin
                        t_reg <= '0;
                    end
                    else if (t_one_reg)
                    begin
                        t_reg <= {1'b1, {pepc_pkg::FRAC_W{1'b0}}};
                    end
                    else
                    begin
                        t_reg <= {1'b0, quo_reg};
                    end
                end
                pepc_pkg::UOP_MUL:
                begin
                    prod_reg <= prod_next;
                end
                pepc_pkg::UOP_ADD:
                begin
                    isect_reg[comp_idx_reg] <= isect_val;
                end
                default: ;
            endcase
        end
    end

    // output register
    assign do_emit = ctrl.exec && ((ctrl.uop == pepc_pkg::UOP_EMIT_ISECT) ||
                                   (ctrl.uop == pepc_pkg::UOP_EMIT_CUR));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_emit)
        begin
            if (ctrl.uop == pepc_pkg::UOP_EMIT_ISECT)
            begin
                out_vtx_reg  <= isect_reg;
                out_last_reg <= (op_reg == pepc_pkg::OP_LEAVE);
            end
            else
            begin
                out_vtx_reg  <= cur_reg;
                out_last_reg <= 1'b1;
            end
        end
    end

    // status toward the sequencer
    assign status.op_pass    = (op_reg == pepc_pkg::OP_PASS);
    assign status.op_no_clip = (op_reg != pepc_pkg::OP_ENTER) &&
                               (op_reg != pepc_pkg::OP_LEAVE);
    assign status.op_leave   = (op_reg == pepc_pkg::OP_LEAVE);
    assign status.div_more   = (div_cnt_reg !=
                                pepc_pkg::DIV_CNT_W'(pepc_pkg::FRAC_W - 1));
    assign status.comp_more  = (comp_idx_reg !=
                                pepc_pkg::COMP_IDX_W'(pepc_pkg::NUM_COMP - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign vtx_out   = out_vtx_reg;
    assign last_out  = out_last_reg;

endmodule

FILE: bench/clip_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_result_checker
// Watches both channels of the edge plane clipper, keeps its own copy of the
// previous vertex, predicts the emitted vertices of every accepted item and
// compares each emitted vertex, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module clip_result_checker
    import pepc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic signed [31:0]  plane_distance,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  tex_u,
    input  logic signed [31:0]  tex_v,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [31:0]  out_x,
    input  logic signed [31:0]  out_y,
    input  logic signed [31:0]  out_z,
    input  logic signed [31:0]  out_u,
    input  logic signed [31:0]  out_v,
    input  logic                last_of_run,
    output int                  mismatch_count,
    output int                  vertices_due
);

    typedef struct packed {
        logic [NUM_COMP-1:0][DATA_W-1:0] comp;
        logic                            last;
    } clip_vertex_t;

    // predicted vertices still to be emitted, oldest first
    clip_vertex_t expected_vertices [$];

    // model copy of the previous vertex
    logic signed [DATA_W-1:0] prev_pos [NUM_COMP];
    logic signed [DATA_W-1:0] prev_dist;

    int    fails;
    int    vertices_seen;
    string comp_name [NUM_COMP] = '{"out_x", "out_y", "out_z", "out_u", "out_v"};

    initial
    begin
        fails = 0;
    end

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    // t = dprev / (dprev - dcur) in unsigned Q1.16, clamped to [0, 1]
    function automatic logic [T_W-1:0] edge_fraction(input logic signed [DATA_W-1:0] dp,
                                                      input logic signed [DATA_W-1:0] dc);
        logic signed [63:0] num;
        logic signed [63:0] cur_d;
        logic signed [63:0] den;
        logic [63:0]        an;
        logic [63:0]        ad;
        num   = dp;
        cur_d = dc;
        den   = num - cur_d;
        // zero denominator or zero numerator
        if (den == 0 || num == 0)
            return '0;
        // negative quotient
        if ((num > 0) != (den > 0))
            return '0;
        an = (num > 0) ? num : -num;
        ad = (den > 0) ? den : -den;
        // quotient of one or more
        if (an >= ad)
            return T_W'(1) << FRAC_W;
        return T_W'((an << FRAC_W) / ad);
    endfunction

    // prev + floor((cur - prev) * t / 2^16)
    function automatic logic [DATA_W-1:0] lerp_component(input logic signed [DATA_W-1:0] p,
                                                          input logic signed [DATA_W-1:0] c,
                                                          input logic [T_W-1:0] t);
        logic signed [63:0] p64;
        logic signed [63:0] c64;
        logic signed [63:0] diff;
        logic signed [63:0] prod;
        p64  = p;
        c64  = c;
        diff = c64 - p64;
        prod = diff * $signed({47'd0, t});
        return DATA_W'(p64 + (prod >>> FRAC_W));
    endfunction

    // expected vertices of one item, then the item becomes the previous vertex
    task automatic predict_clip_outputs(input logic [OP_W-1:0] op,
                                        input logic signed [DATA_W-1:0] d,
                                        input logic signed [DATA_W-1:0] cx,
                                        input logic signed [DATA_W-1:0] cy,
                                        input logic signed [DATA_W-1:0] cz,
                                        input logic signed [DATA_W-1:0] cu,
                                        input logic signed [DATA_W-1:0] cv);
        logic signed [DATA_W-1:0] cur [NUM_COMP];
        logic [T_W-1:0]           t;
        clip_vertex_t             hit;
        clip_vertex_t             here;
        cur[0] = cx;
        cur[1] = cy;
        cur[2] = cz;
        cur[3] = cu;
        cur[4] = cv;
        t = edge_fraction(prev_dist, d);
        for (int i = 0; i < NUM_COMP; i++)
        begin
            hit.comp[i]  = lerp_component(prev_pos[i], cur[i], t);
            here.comp[i] = cur[i];
        end
        case (op)
            OP_PASS:
            begin
                here.last = 1'b1;
                expected_vertices.push_back(here);
            end
            OP_ENTER:
            begin
                hit.last  = 1'b0;
                here.last = 1'b1;
                expected_vertices.push_back(hit);
                expected_vertices.push_back(here);
            end
            OP_LEAVE:
            begin
                hit.last = 1'b1;
                expected_vertices.push_back(hit);
            end
            default:
            begin
                // both outside, load only and the spare codes emit nothing
            end
        endcase
        for (int i = 0; i < NUM_COMP; i++)
            prev_pos[i] = cur[i];
        prev_dist = d;
    endtask

    // compare one emitted vertex with the oldest prediction
    task automatic check_vertex();
        clip_vertex_t             want;
        logic signed [DATA_W-1:0] got [NUM_COMP];
        got[0] = out_x;
        got[1] = out_y;
        got[2] = out_z;
        got[3] = out_u;
        got[4] = out_v;
        if (expected_vertices.size() == 0)
        begin
            report_mismatch($sformatf("vertex %0d emitted with none expected: x=%h last=%b",
                                      vertices_seen, out_x, last_of_run));
        end
        else
        begin
            want = expected_vertices.pop_front();
            for (int i = 0; i < NUM_COMP; i++)
            begin
                if (got[i] != want.comp[i])
                    report_mismatch($sformatf("vertex %0d %s got %h want %h", vertices_seen,
                                              comp_name[i], got[i], want.comp[i]));
            end
            if (last_of_run != want.last)
                report_mismatch($sformatf("vertex %0d last_of_run got %b want %b",
                                          vertices_seen, last_of_run, want.last));
        end
        vertices_seen++;
    endtask

    // sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COMP; i++)
                prev_pos[i] = '0;
            prev_dist = '0;
            expected_vertices.delete();
            vertices_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_vertex();
            if (in_valid && in_ready)
            begin
                predict_clip_outputs(opcode, plane_distance, pos_x, pos_y, pos_z,
                                     tex_u, tex_v);
            end
        end
        mismatch_count <= fails;
        vertices_due   <= expected_vertices.size();
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the polygon edge plane clipper: a directed pass
// over the edge cases and value extremes, then random polygons fed as
// well-formed edge sequences mixed with noise, under bursty input and a
// stalling receiver. The checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb_top;
    import pepc_pkg::*;

    localparam int     CLK_PERIOD    = 10;
    localparam int     RESET_CYCLES  = 11;
    localparam int     RANDOM_ITEMS  = 1500;
    localparam int     SETTLE_CYCLES = 60;
    localparam int     MAX_SIDES     = 8;
    localparam longint RUN_LIMIT_NS  = 64'd6_000_000;

    // edge cases that emit nothing
    localparam logic [OP_W-1:0] OP_BOTH_OUT    = OP_W'(3);
    localparam logic [OP_W-1:0] OP_LOAD_ONLY   = OP_W'(4);
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = OP_W'(5);
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = OP_W'(7);

    localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] Q_MIN = 32'sh80000000;
    localparam logic signed [31:0] Q_ONE = 32'sh00010000;

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               in_valid       = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    opcode         = '0;
    logic signed [31:0] plane_distance = '0;
    logic signed [31:0] pos_x          = '0;
    logic signed [31:0] pos_y          = '0;
    logic signed [31:0] pos_z          = '0;
    logic signed [31:0] tex_u          = '0;
    logic signed [31:0] tex_v          = '0;
    logic               out_valid;
    logic               out_ready      = 1'b0;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;
    logic               last_of_run;

    int mismatch_count;
    int vertices_due;
    int items_sent = 0;
    int burst_left = 0;
    int stall_left = 0;
    int sink_mode  = 0;
    int sink_left  = 0;

    polygon_edge_plane_clip_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .plane_distance (plane_distance),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .out_u          (out_u),
        .out_v          (out_v),
        .last_of_run    (last_of_run)
    );

    clip_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .plane_distance (plane_distance),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_z          (out_z),
        .out_u          (out_u),
        .out_v          (out_v),
        .last_of_run    (last_of_run),
        .mismatch_count (mismatch_count),
        .vertices_due   (vertices_due)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // present one item at the falling edge and hold it until taken
    task automatic send_vertex(input logic [OP_W-1:0] op, input logic [31:0] d,
                               input logic [31:0] x, input logic [31:0] y,
                               input logic [31:0] z, input logic [31:0] u,
                               input logic [31:0] v);
        opcode         <= op;
        plane_distance <= d;
        pos_x          <= x;
        pos_y          <= y;
        pos_z          <= z;
        tex_u          <= u;
        tex_v          <= v;
        in_valid       <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
        // bursts of back-to-back items, then a gap of random length
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            in_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(15, 40)) @(negedge clk);
            else
                repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    function automatic logic [31:0] pick_distance();
        case ($urandom_range(0, 9)) inside
            0:       return '0;
            1:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            [2:4]:   return $urandom;
            default: return 32'($urandom_range(0, 32'h200000)) - 32'h100000;
        endcase
    endfunction

    function automatic logic [31:0] pick_coord();
        if ($urandom_range(0, 1))
            return $urandom;
        return 32'($urandom_range(0, 32'h2000000)) - 32'h1000000;
    endfunction

    // one polygon against the plane: load the closing vertex, then walk the edges
    task automatic send_polygon();
        int                 sides;
        int                 back;
        logic [31:0]        side_dist [MAX_SIDES];
        logic [31:0]        pt [MAX_SIDES][NUM_COMP];
        logic [OP_W-1:0]    op;
        logic               prev_in;
        logic               cur_in;
        sides = $urandom_range(3, MAX_SIDES);
        for (int k = 0; k < sides; k++)
        begin
            side_dist[k] = pick_distance();
            for (int c = 0; c < NUM_COMP; c++)
                pt[k][c] = pick_coord();
        end
        // now and then the load is skipped, leaving a stale previous vertex
        if ($urandom_range(0, 19) != 0)
            send_vertex(OP_LOAD_ONLY, side_dist[sides-1], pt[sides-1][0], pt[sides-1][1],
                        pt[sides-1][2], pt[sides-1][3], pt[sides-1][4]);
        for (int k = 0; k < sides; k++)
        begin
            back    = (k == 0) ? sides - 1 : k - 1;
            prev_in = !side_dist[back][31];
            cur_in  = !side_dist[k][31];
            if (prev_in)
                op = cur_in ? OP_PASS : OP_LEAVE;
            else
                op = cur_in ? OP_ENTER : OP_BOTH_OUT;
            // a broken sequence: the edge case does not match the signs
            if ($urandom_range(0, 14) == 0)
                op = OP_W'($urandom_range(0, 7));
            send_vertex(op, side_dist[k], pt[k][0], pt[k][1], pt[k][2], pt[k][3],
                        pt[k][4]);
        end
    endtask

    // receiver: stall pattern is redrawn at random from three modes
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_left == 0)
            begin
                sink_mode = $urandom_range(0, 2);
                sink_left = 300;
            end
            else
            begin
                sink_left--;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                case (sink_mode)
                    1:       stall_left = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 0;
                    2:       stall_left = ($urandom_range(0, 9) < 3) ? $urandom_range(4, 16) : 0;
                    default: stall_left = 0;
                endcase
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int start_count;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // leaving edge straight after reset: zero numerator, result is the origin
        send_vertex(OP_LEAVE, 3 * Q_ONE, Q_ONE, 2 * Q_ONE, -Q_ONE, Q_MAX, Q_MIN);
        // field extremes through the pass case
        send_vertex(OP_PASS, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
        send_vertex(OP_PASS, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        // entering edge at a quarter, then leaving at three eighths
        send_vertex(OP_LOAD_ONLY, -Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 4 * Q_ONE, 5 * Q_ONE);
        send_vertex(OP_ENTER, 3 * Q_ONE, 5 * Q_ONE, -2 * Q_ONE, 32'sh7fff0000, '0, Q_MIN);
        send_vertex(OP_LEAVE, -5 * Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        // zero denominator
        send_vertex(OP_LOAD_ONLY, 5, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_vertex(OP_ENTER, 5, $urandom, $urandom, $urandom, $urandom, $urandom);
        // numerator and denominator of opposite sign
        send_vertex(OP_LOAD_ONLY, Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_vertex(OP_LEAVE, 2 * Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        // quotient of one or more, and a current distance of zero
        send_vertex(OP_LOAD_ONLY, 2 * Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_vertex(OP_LEAVE, Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_vertex(OP_LOAD_ONLY, -Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_vertex(OP_ENTER, '0, $urandom, $urandom, $urandom, $urandom, $urandom);
        // widest distance span and widest component span, both directions
        send_vertex(OP_LOAD_ONLY, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send_vertex(OP_LEAVE, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        send_vertex(OP_LOAD_ONLY, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send_vertex(OP_ENTER, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
        // t just below one, then t that floors to zero
        send_vertex(OP_LOAD_ONLY, -(Q_ONE - 1), Q_MIN, '0, Q_MAX, -1, 1);
        send_vertex(OP_ENTER, 1, Q_MAX, -1, Q_MIN, 1, -1);
        send_vertex(OP_LOAD_ONLY, 1, $urandom, $urandom, $urandom, $urandom, $urandom);
        send_vertex(OP_LEAVE, Q_MIN, $urandom, $urandom, $urandom, $urandom, $urandom);
        // both outside and the spare codes still move the previous vertex
        send_vertex(OP_BOTH_OUT, -3 * Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int op_code = OP_SPARE_FIRST; op_code <= OP_SPARE_LAST; op_code++)
            send_vertex(OP_W'(op_code), $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom);
        send_vertex(OP_ENTER, 7 * Q_ONE, $urandom, $urandom, $urandom, $urandom, $urandom);

        // random polygons with some noise items between them
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
                send_polygon();
            else
                send_vertex(OP_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
        end
        in_valid <= 1'b0;

        // drain, then let any item with no result finish
        while (vertices_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
